>>> hdl/rawin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawin_pkg: shared types and constants for the rolling window checksum
// Widths, modulus constants and the records passed between pipeline stages.
// ----------------------------------------------------------------------------
package rawin_pkg;

    // ring depth in bytes; must be a power of two (the ring pointer wraps)
    localparam int MAX_WINDOW = 4096;
    localparam int RING_AW    = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W      = 13;
    localparam int POS_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int SUM_W      = 16;
    localparam int PROD_W     = LEN_W + BYTE_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd1024;

    // checksum modulus and its helpers; 2^16 - ADLER_MOD folds the high bits
    localparam logic [16:0] ADLER_MOD    = 17'd65521;
    localparam logic [17:0] ADLER_MOD_X2 = 18'd131042;
    localparam logic [16:0] FOLD_K       = 17'd15;

    // word leaving the front stage
    typedef struct packed {
        logic              valid;
        logic              roll;
        logic              emit;
        logic              restart;
        logic [BYTE_W-1:0] in_byte;
        logic [POS_W-1:0]  offset;
    } t_front;

    // word after the product stage
    typedef struct packed {
        logic              valid;
        logic              roll;
        logic              emit;
        logic              restart;
        logic [BYTE_W-1:0] in_byte;
        logic [BYTE_W-1:0] oldest;
        logic [POS_W-1:0]  offset;
    } t_prod;

    // word entering the accumulator: increments already reduced
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             restart;
        logic [SUM_W-1:0] inc_a;
        logic [SUM_W-1:0] inc_b;
        logic [POS_W-1:0] offset;
    } t_delta;

endpackage

>>> hdl/rawin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawin_ram: byte ring store
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module rawin_ram
    import rawin_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [RING_AW-1:0] i_wa,
    input  logic [BYTE_W-1:0]  i_wd,
    input  logic               i_re,
    input  logic [RING_AW-1:0] i_ra,
    output logic [BYTE_W-1:0]  o_rd
);

    logic [BYTE_W-1:0] mem [MAX_WINDOW];
    logic [BYTE_W-1:0] r_rd;

    // read-first storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

>>> hdl/rawin_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawin_front: window bookkeeping
// Holds the window length, fill count, ring pointer and stream position,
// decides roll and emit for each accepted byte and drives the ring ports.
// ----------------------------------------------------------------------------
module rawin_front
    import rawin_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [BYTE_W-1:0]  i_byte,
    input  logic               i_restart,
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    output logic               o_ring_we,
    output logic [RING_AW-1:0] o_ring_wa,
    output logic [RING_AW-1:0] o_ring_ra,
    output logic [LEN_W-1:0]   o_len,
    output t_front             o_s1
);

    logic [CFG_W-1:0]   r_cfg_len;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [RING_AW-1:0] r_ptr;
    logic [POS_W-1:0]   r_pos, n_pos;
    t_front             r_s1;

    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_fill_cur;
    logic [POS_W-1:0]   w_idx;
    logic               w_accept;
    logic               w_roll;

    // clamp the configured length into 1..MAX_WINDOW
    always_comb begin
        if (r_cfg_len == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(r_cfg_len) > MAX_WINDOW) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(r_cfg_len);
        end
    end

    // per-byte decisions; restart clears fill and position first
    always_comb begin
        w_accept   = i_valid && i_en;
        w_fill_cur = i_restart ? '0 : r_fill;
        w_idx      = i_restart ? '0 : r_pos;
        w_roll     = (w_fill_cur >= w_len);
        n_fill     = w_roll ? w_fill_cur : w_fill_cur + LEN_W'(1);
        n_pos      = w_idx + POS_W'(1);
    end

    // config register and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= CFG_RESET;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_pos     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_len <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_fill <= n_fill;
                r_ptr  <= r_ptr + RING_AW'(1);
                r_pos  <= n_pos;
            end
        end
    end

    // stage 1 word, advances with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1.valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.roll    <= w_roll;
            r_s1.emit    <= (n_fill >= w_len);
            r_s1.restart <= i_restart;
            r_s1.in_byte <= i_byte;
            r_s1.offset  <= w_idx + POS_W'(1) - POS_W'(w_len);
        end
    end

    // ring: write new byte, read the byte leaving the window
    assign o_ring_we = w_accept;
    assign o_ring_wa = r_ptr;
    assign o_ring_ra = r_ptr - w_len[RING_AW-1:0];
    assign o_len     = w_len;
    assign o_s1      = r_s1;

endmodule

>>> hdl/rawin_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawin_delta: sum increments
// Two stages: length times oldest byte, then the reduced increments that
// the accumulator adds to a and b.
// ----------------------------------------------------------------------------
module rawin_delta
    import rawin_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_front            i_s1,
    input  logic [BYTE_W-1:0] i_oldest,
    input  logic [LEN_W-1:0]  i_len,
    output t_delta            o_s3
);

    t_prod              r_s2;
    logic [PROD_W-1:0]  r_prod;
    t_delta             r_s3;

    logic [16:0]        w_fold;
    logic [SUM_W-1:0]   w_drop;
    logic [16:0]        w_da;
    logic [17:0]        w_db;
    logic [SUM_W-1:0]   w_inc_a;
    logic [SUM_W-1:0]   w_inc_b;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s2.valid <= i_s1.valid;
            r_s3.valid <= r_s2.valid;
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2.roll    <= i_s1.roll;
            r_s2.emit    <= i_s1.emit;
            r_s2.restart <= i_s1.restart;
            r_s2.in_byte <= i_s1.in_byte;
            r_s2.oldest  <= i_oldest;
            r_s2.offset  <= i_s1.offset;
            r_prod       <= PROD_W'(i_len) * PROD_W'(i_oldest);
        end
    end

    // fold the product mod ADLER_MOD: 2^16 is 15 above the modulus
    always_comb begin
        w_fold = 17'(r_prod[15:0]) + 17'(r_prod >> 16) * FOLD_K;
        w_drop = (w_fold >= ADLER_MOD) ? SUM_W'(w_fold - ADLER_MOD) : SUM_W'(w_fold);
    end

    // increments: a += new - old, b += a + new - old - 1 - drop
    always_comb begin
        w_da = 17'(r_s2.in_byte) + ADLER_MOD - 17'(r_s2.oldest);
        w_db = 18'(r_s2.in_byte) + ADLER_MOD_X2 - 18'd1 - 18'(r_s2.oldest) - 18'(w_drop);
        if (r_s2.roll) begin
            w_inc_a = (w_da >= ADLER_MOD) ? SUM_W'(w_da - ADLER_MOD) : SUM_W'(w_da);
            if (w_db >= ADLER_MOD_X2) begin
                w_inc_b = SUM_W'(w_db - ADLER_MOD_X2);
            end else if (w_db >= 18'(ADLER_MOD)) begin
                w_inc_b = SUM_W'(w_db - 18'(ADLER_MOD));
            end else begin
                w_inc_b = SUM_W'(w_db);
            end
        end else begin
            w_inc_a = SUM_W'(r_s2.in_byte);
            w_inc_b = SUM_W'(r_s2.in_byte);
        end
    end

    // increment stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3.emit    <= r_s2.emit;
            r_s3.restart <= r_s2.restart;
            r_s3.inc_a   <= w_inc_a;
            r_s3.inc_b   <= w_inc_b;
            r_s3.offset  <= r_s2.offset;
        end
    end

    assign o_s3 = r_s3;

endmodule

>>> hdl/rawin_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rawin_accum: running sums and output register
// Adds the increments to a and b once per word and loads the result word.
// ----------------------------------------------------------------------------
module rawin_accum
    import rawin_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  t_delta                         i_s3,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [2*SUM_W+POS_W-1:0]       o_out_data
);

    logic [SUM_W-1:0] r_a, n_a;
    logic [SUM_W-1:0] r_b, n_b;
    logic             r_out_valid;
    logic [2*SUM_W+POS_W-1:0] r_out_data;

    logic [SUM_W-1:0] w_a_cur;
    logic [SUM_W-1:0] w_b_cur;
    logic [16:0]      w_a_sum;
    logic [17:0]      w_b_sum;

    // b takes the old a: inc_b holds the rest of a_new - 1 - drop
    always_comb begin
        w_a_cur = i_s3.restart ? SUM_W'(1) : r_a;
        w_b_cur = i_s3.restart ? '0 : r_b;
        w_a_sum = 17'(w_a_cur) + 17'(i_s3.inc_a);
        w_b_sum = 18'(w_b_cur) + 18'(w_a_cur) + 18'(i_s3.inc_b);
        n_a = (w_a_sum >= ADLER_MOD) ? SUM_W'(w_a_sum - ADLER_MOD) : SUM_W'(w_a_sum);
        if (w_b_sum >= ADLER_MOD_X2) begin
            n_b = SUM_W'(w_b_sum - ADLER_MOD_X2);
        end else if (w_b_sum >= 18'(ADLER_MOD)) begin
            n_b = SUM_W'(w_b_sum - 18'(ADLER_MOD));
        end else begin
            n_b = SUM_W'(w_b_sum);
        end
    end

    // sums and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= SUM_W'(1);
            r_b         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_en && i_s3.valid) begin
                r_a <= n_a;
                r_b <= n_b;
            end
            if (i_en) begin
                r_out_valid <= i_s3.valid && i_s3.emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_en && i_s3.valid && i_s3.emit) begin
            r_out_data <= {i_s3.offset, n_b, n_a};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hdl/rolling_adler32_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_adler32_window_top: sliding-window Adler-32 over a byte stream
// Each input word carries one byte; tuser set marks the first byte of a new
// stream (sums restart at a=1, b=0, offset counting restarts at 0). Once the
// window of i_cfg_wr_data bytes is full, every byte yields one output word:
// sum_a, sum_b and the stream offset of the window's first byte.
// Throughput: one byte per cycle while the output is not stalled. The sums
// feed back through a register in the accumulator; the oldest byte comes from
// a ring RAM with one registered read port, read at the same cycle the new
// byte is written. From input accept to output valid a word passes, each step
// registered: ring read, length*oldest product, increment reduction, accumulate.
// Stall: the whole pipeline holds while an output word waits; s_axis_tready
// is high whenever the output register is empty or being taken.
// Reset: sums, counters and valid bits clear, window length returns to 1024;
// ring contents are left as they are and never used before being written.
// Configuration: write the length only while no word is in flight.
// ----------------------------------------------------------------------------
module rolling_adler32_window_top
    import rawin_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration: window_length
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_W-1:0]         i_cfg_wr_data,
    // byte input
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [7:0]               i_s_axis_tdata,   // [7:0] in_byte
    input  logic                     i_s_axis_tuser,   // [0] restart
    // checksum output
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [63:0]              o_m_axis_tdata    // [15:0] sum_a, [31:16] sum_b,
                                                       // [63:32] window_offset
);

    logic               w_en;
    logic               w_ring_we;
    logic [RING_AW-1:0] w_ring_wa;
    logic [RING_AW-1:0] w_ring_ra;
    logic [BYTE_W-1:0]  w_oldest;
    logic [LEN_W-1:0]   w_len;
    t_front             w_s1;
    t_delta             w_s3;

    // global advance: output register empty or draining
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    rawin_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .i_restart     (i_s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_ring_we     (w_ring_we),
        .o_ring_wa     (w_ring_wa),
        .o_ring_ra     (w_ring_ra),
        .o_len         (w_len),
        .o_s1          (w_s1)
    );

    rawin_ram u_ram (
        .i_clk (i_clk),
        .i_we  (w_ring_we),
        .i_wa  (w_ring_wa),
        .i_wd  (i_s_axis_tdata),
        .i_re  (w_ring_we),
        .i_ra  (w_ring_ra),
        .o_rd  (w_oldest)
    );

    rawin_delta u_delta (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_s1     (w_s1),
        .i_oldest (w_oldest),
        .i_len    (w_len),
        .o_s3     (w_s3)
    );

    rawin_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_s3        (w_s3),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // a rolling byte always belongs to a full window, so it must emit
    a_roll_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1.valid && w_s1.roll |-> w_s1.emit)
        else $error("rolling byte without result");

    // a window completed by a restart byte starts at offset zero
    a_restart_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1.valid && w_s1.restart && w_s1.emit |-> w_s1.offset == '0)
        else $error("restart window offset not zero");

    // both sums are fully reduced
    a_sums_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (17'(o_m_axis_tdata[15:0]) < ADLER_MOD) &&
                            (17'(o_m_axis_tdata[31:16]) < ADLER_MOD))
        else $error("checksum sum out of range");

    // an accepted byte shows up as a valid stage 1 word
    a_ring_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> w_s1.valid)
        else $error("accepted byte lost before stage 1");
`endif

endmodule

>>> tb/adler_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adler_window_checker: scoreboard for the rolling window checksum
// Watches the byte, checksum and length-write channels. It keeps its own
// copy of the ring, sums and counters and computes the checksum word due
// for every accepted byte that completes a window. Each output word is then
// compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module adler_window_checker
    import rawin_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_byte_tvalid,
    input  logic             i_byte_tready,
    input  logic [7:0]       i_byte_tdata,   // [7:0] in_byte
    input  logic             i_byte_tuser,   // [0] restart
    input  logic             i_sum_tvalid,
    input  logic             i_sum_tready,
    input  logic [63:0]      i_sum_tdata,    // [15:0] sum_a, [31:16] sum_b,
                                             // [63:32] window_offset
    output int               o_mismatches,
    output int               o_sums_pending
);

    localparam int unsigned MODULUS = ADLER_MOD;

    // one checksum word; sum_a sits in the lowest bits as on the bus
    typedef struct packed {
        logic [31:0] offset;
        logic [15:0] sum_b;
        logic [15:0] sum_a;
    } t_window_sum;

    logic [7:0]       ring [MAX_WINDOW];
    int unsigned      a_sum;
    int unsigned      b_sum;
    int unsigned      fill;
    int unsigned      wr_slot;
    int unsigned      stream_pos;
    logic [CFG_W-1:0] win_len_reg;
    t_window_sum      sums_due [$];
    int               mismatches;

    initial begin
        mismatches     = 0;
        o_mismatches   = 0;
        o_sums_pending = 0;
        wr_slot        = 0;
    end

    // zero acts as one, anything past the ring depth as the full ring
    function automatic int unsigned active_length(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_WINDOW) return MAX_WINDOW;
        return v;
    endfunction

    // fold one byte into the window and queue the checksum word it yields
    task automatic roll_window_sum(input logic [7:0] value, input logic restart);
        int unsigned len;
        int unsigned start;
        int unsigned old_slot;
        int unsigned oldest;
        int unsigned drop;
        t_window_sum entry;
        len = active_length(win_len_reg);
        if (restart) begin
            a_sum      = 1;
            b_sum      = 0;
            fill       = 0;
            stream_pos = 0;
        end
        start = stream_pos;
        if (fill >= len) begin
            // window full: add the new byte, take out the oldest
            old_slot = (wr_slot + MAX_WINDOW - len) % MAX_WINDOW;
            oldest   = ring[old_slot];
            drop     = (len * oldest) % MODULUS;
            a_sum    = (a_sum + value + MODULUS - oldest) % MODULUS;
            b_sum    = (b_sum + a_sum + 2 * MODULUS - 1 - drop) % MODULUS;
        end else begin
            a_sum = (a_sum + value) % MODULUS;
            b_sum = (b_sum + a_sum) % MODULUS;
            fill++;
        end
        ring[wr_slot] = value;
        wr_slot       = (wr_slot + 1) % MAX_WINDOW;
        stream_pos    = start + 1;
        if (fill >= len) begin
            entry.sum_a  = a_sum[15:0];
            entry.sum_b  = b_sum[15:0];
            entry.offset = start + 1 - len;
            sums_due.push_back(entry);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // outputs are checked before the byte of the same edge is predicted
    always @(posedge i_clk) begin
        t_window_sum got;
        t_window_sum want;
        if (!i_rst_n) begin
            a_sum       = 1;
            b_sum       = 0;
            fill        = 0;
            wr_slot     = 0;
            stream_pos  = 0;
            win_len_reg = CFG_RESET;
            sums_due.delete();
        end else begin
            if (i_sum_tvalid && i_sum_tready) begin
                got = i_sum_tdata;
                if (sums_due.size() == 0) begin
                    $display("%0t: checksum word with none due: expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = sums_due.pop_front();
                    compare_field("sum_a", want.sum_a, got.sum_a);
                    compare_field("sum_b", want.sum_b, got.sum_b);
                    compare_field("window_offset", want.offset, got.offset);
                end
            end
            if (i_cfg_wr_en)
                win_len_reg = i_cfg_wr_data;
            if (i_byte_tvalid && i_byte_tready)
                roll_window_sum(i_byte_tdata, i_byte_tuser);
        end
        o_mismatches   <= mismatches;
        o_sums_pending <= sums_due.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for rolling_adler32_window_top
// Drives byte streams over a range of window lengths with random gaps on
// the input and random back-pressure on the output. A short directed part
// covers length zero, restarts and length changes mid-stream. The
// checker beside the block predicts and compares every checksum word.
// ----------------------------------------------------------------------------
module tb_top;
    import rawin_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int FLUSH_CYCLES = 12;     // pipeline is four deep; margin on top

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data  = '0;
    logic             byte_tvalid  = 1'b0;
    logic             byte_tready;
    logic [7:0]       byte_tdata   = '0;
    logic             byte_tuser   = 1'b0;
    logic             sum_tvalid;
    logic             sum_tready   = 1'b0;
    logic [63:0]      sum_tdata;
    logic             calm         = 1'b0;   // no gaps or stalls while set
    int               mismatches;
    int               sums_pending;
    int               cycles       = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rolling_adler32_window_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (byte_tvalid),
        .o_s_axis_tready (byte_tready),
        .i_s_axis_tdata  (byte_tdata),
        .i_s_axis_tuser  (byte_tuser),
        .o_m_axis_tvalid (sum_tvalid),
        .i_m_axis_tready (sum_tready),
        .o_m_axis_tdata  (sum_tdata)
    );

    adler_window_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_byte_tvalid  (byte_tvalid),
        .i_byte_tready  (byte_tready),
        .i_byte_tdata   (byte_tdata),
        .i_byte_tuser   (byte_tuser),
        .i_sum_tvalid   (sum_tvalid),
        .i_sum_tready   (sum_tready),
        .i_sum_tdata    (sum_tdata),
        .o_mismatches   (mismatches),
        .o_sums_pending (sums_pending)
    );

    // output back-pressure
    always @(posedge clk)
        sum_tready <= calm || ($urandom_range(99) >= 26);

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // bytes lean toward the extremes
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // one word on the byte channel, with random gaps ahead of it
    task automatic send_byte(input logic [7:0] value, input logic restart);
        while (!calm && $urandom_range(99) < 26) begin
            byte_tvalid <= 1'b0;
            @(posedge clk);
        end
        byte_tvalid <= 1'b1;
        byte_tdata  <= value;
        byte_tuser  <= restart;
        @(posedge clk);
        while (!byte_tready)
            @(posedge clk);
    endtask

    // stop sending until every checksum word is out and the pipeline is empty
    task automatic settle();
        byte_tvalid <= 1'b0;
        @(posedge clk);
        while (sums_pending != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random stream at one length; restarts roughly per_mille in a thousand
    task automatic run_stream(input logic [CFG_W-1:0] len, input int count,
                              input int per_mille, input logic open_restart);
        write_length(len);
        for (int i = 0; i < count; i++)
            send_byte(pick_byte(),
                      (i == 0 && open_restart) || ($urandom_range(999) < per_mille));
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // length zero behaves as one: every byte is a full window
        write_length(13'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);

        // short window, all-ones bytes, then a restart mid-stream
        write_length(13'd3);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);

        // shrink without restart: fill stays above the new length
        write_length(13'd2);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);

        // grow without restart: fill resumes counting up
        write_length(13'd5);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0);

        // random streams
        run_stream(13'd1, 60, 30, 1'b1);
        run_stream(13'd2, 60, 30, 1'b1);
        run_stream(13'd7, 80, 20, 1'b1);
        run_stream(13'd16, 100, 10, 1'b1);
        run_stream(13'd100, 150, 0, 1'b0);
        calm <= 1'b1;
        run_stream(13'd300, 450, 0, 1'b1);
        calm <= 1'b0;
        // over-range lengths act as the full ring: no word before it fills
        run_stream(13'd8191, 120, 0, 1'b1);
        run_stream(13'd4097, 30, 0, 1'b0);
        // shrink from a long partial window without restart
        run_stream(13'd5, 80, 30, 1'b0);
        run_stream(13'd33, 200, 15, 1'b1);

        settle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/rawin_pkg.sv
hdl/rawin_ram.sv
hdl/rawin_front.sv
hdl/rawin_delta.sv
hdl/rawin_accum.sv
hdl/rolling_adler32_window_top.sv
tb/adler_window_checker.sv
tb/tb_top.sv
